// ===== hdl/quicksort_hoare_partition_unit_defines.svh =====
// Assertion macros used by the top-level RTL file.
`ifndef QUICKSORT_HOARE_PARTITION_UNIT_DEFINES_SVH
`define QUICKSORT_HOARE_PARTITION_UNIT_DEFINES_SVH

// Same-cycle implication.
`define QSHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define QSHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/qshp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package qshp_pkg;

  localparam int unsigned QSHP_DEPTH = 64;
  localparam int unsigned QSHP_VW    = 32;

  typedef struct packed {
    logic                     vld;
    logic signed [QSHP_VW-1:0] val;
    logic                     gt;
  } qshp_link_t;

  typedef struct packed {
    logic                     ins;
    logic                     shift;
    logic signed [QSHP_VW-1:0] val;
  } qshp_cmd_t;

endpackage
`default_nettype wire

// ===== hdl/qshp_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
module qshp_cell
  import qshp_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire qshp_cmd_t  cmd_i,
  input  wire qshp_link_t left_i,
  input  wire qshp_link_t right_i,
  output qshp_link_t      link_o
);

  logic                      vld_q, vld_d;
  logic signed [QSHP_VW-1:0] val_q, val_d;
  logic                      gt;

  assign gt = !vld_q || ($signed(cmd_i.val) < $signed(val_q));

  always_comb begin
    vld_d = vld_q;
    val_d = val_q;
    priority if (cmd_i.ins && gt) begin
      if (left_i.gt) begin
        vld_d = left_i.vld;
        val_d = left_i.val;
      end else begin
        vld_d = 1'b1;
        val_d = cmd_i.val;
      end
    end else if (cmd_i.shift) begin
      vld_d = right_i.vld;
      val_d = right_i.val;
    end else begin
      vld_d = vld_q;
      val_d = val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o.vld = vld_q;
  assign link_o.val = val_q;
  assign link_o.gt  = gt;

endmodule
`default_nettype wire

// ===== hdl/quicksort_hoare_partition_unit.sv =====
// Load: one value per cycle while loading; each accepted value is placed in order on the edge it arrives.
// Sort: the first result is offered in the cycle after the final transaction is accepted.
// Emit: one result per cycle from the head cell while out_ready_i is high.
// The set is held in a row of DEPTH compare-and-shift cells; a value accepted while they are full is dropped.
// Reset clears the cell valid bits, the fill count and the drop flag; value storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none
`include "quicksort_hoare_partition_unit_defines.svh"
module quicksort_hoare_partition_unit
  import qshp_pkg::*;
#(
  parameter int unsigned DEPTH = QSHP_DEPTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire logic signed [QSHP_VW-1:0] sample_value_i,
  input  wire logic                      final_item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic signed [QSHP_VW-1:0]      sorted_value_o,
  output logic                           end_of_run_o,
  output logic                           overflowed_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic {ST_LOAD, ST_EMIT} state_e;

  state_e         state_q;
  logic [CW-1:0]  count_q;
  logic           drop_q;
  logic           full;
  logic           in_fire;
  logic           out_fire;
  qshp_cmd_t      cmd;
  qshp_link_t     lnk [DEPTH];
  qshp_link_t     tie;

  assign full     = (count_q == CW'(DEPTH));
  assign in_ready_o  = (state_q == ST_LOAD);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_fire  = in_valid_i && in_ready_o;
  assign out_fire = out_valid_o && out_ready_i;

  assign cmd.ins   = in_fire && !full;
  assign cmd.shift = out_fire;
  assign cmd.val   = sample_value_i;

  assign tie.vld = 1'b0;
  assign tie.val = '0;
  assign tie.gt  = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    qshp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd),
      .left_i  ((i == 0) ? tie : lnk[(i == 0) ? 0 : i - 1]),
      .right_i ((i == DEPTH - 1) ? tie : lnk[(i == DEPTH - 1) ? i : i + 1]),
      .link_o  (lnk[i])
    );
  end

  assign sorted_value_o = lnk[0].val;
  assign end_of_run_o   = !lnk[1].vld;
  assign overflowed_o   = drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      count_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_LOAD: begin
          if (in_fire) begin
            if (full) begin
              drop_q <= 1'b1;
            end else begin
              count_q <= count_q + CW'(1);
            end
            if (final_item_i) begin
              state_q <= ST_EMIT;
            end
          end
        end
        ST_EMIT: begin
          if (out_fire && end_of_run_o) begin
            state_q <= ST_LOAD;
            count_q <= '0;
            drop_q  <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_LOAD;
        end
      endcase
    end
  end

  `QSHP_ASSERT_IMP(a_head_valid, clk_i, rst_ni, out_valid_o, lnk[0].vld, "head cell empty while emitting")
  `QSHP_ASSERT_IMP(a_head_order, clk_i, rst_ni, out_valid_o && lnk[1].vld, $signed(lnk[0].val) <= $signed(lnk[1].val), "head cells out of order")
  `QSHP_ASSERT_NXT(a_drop_set, clk_i, rst_ni, in_fire && full, drop_q, "drop not recorded")
  `QSHP_ASSERT_NXT(a_final_emit, clk_i, rst_ni, in_fire && final_item_i, state_q == ST_EMIT, "final transaction did not start emit")
  `QSHP_ASSERT_NXT(a_run_done, clk_i, rst_ni, out_fire && end_of_run_o, (state_q == ST_LOAD) && (count_q == '0) && !lnk[0].vld, "run did not close cleanly")

endmodule
`default_nettype wire
